// File: design/configurable_crc_engine_defines.svh
// Assertion macros used by the CRC engine checker
`ifndef CONFIGURABLE_CRC_ENGINE_DEFINES_SVH
`define CONFIGURABLE_CRC_ENGINE_DEFINES_SVH

// same-cycle implication
`define CCE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cce check failed");

// next-cycle implication
`define CCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cce check failed");

`endif

// File: design/cce_pkg.sv
// Types, constants and helpers shared by the CRC engine
package cce_pkg;

   localparam int CFG_WORD_WIDTH    = 32;
   localparam int CRC_WIDTH_BITS    = 6;
   localparam int CRC_OUT_WIDTH     = 32;
   localparam int BYTE_WIDTH        = 8;
   localparam int CSR_ADDR_WIDTH    = 5;
   localparam int REG_INDEX_WIDTH   = 3;
   localparam int MAX_WIDTH_DEFAULT = 32;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_POLYNOMIAL     = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_CRC_WIDTH      = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_INITIAL_VALUE  = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_REFLECT_INPUT  = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_REFLECT_OUTPUT = 3'd4;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_FINAL_XOR      = 3'd5;

   localparam logic [CFG_WORD_WIDTH-1:0] RST_POLYNOMIAL     = 32'h04C1_1DB7;
   localparam logic [CRC_WIDTH_BITS-1:0] RST_CRC_WIDTH      = 6'd32;
   localparam logic [CFG_WORD_WIDTH-1:0] RST_INITIAL_VALUE  = 32'hFFFF_FFFF;
   localparam logic                      RST_REFLECT_INPUT  = 1'b1;
   localparam logic                      RST_REFLECT_OUTPUT = 1'b1;
   localparam logic [CFG_WORD_WIDTH-1:0] RST_FINAL_XOR      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [CFG_WORD_WIDTH-1:0] polynomial;
      logic [CRC_WIDTH_BITS-1:0] crc_width;
      logic [CFG_WORD_WIDTH-1:0] initial_value;
      logic                      reflect_input;
      logic                      reflect_output;
      logic [CFG_WORD_WIDTH-1:0] final_xor;
      logic                      restart;
   } cce_cfg_type;

   function automatic logic [BYTE_WIDTH-1:0] rev8(input logic [BYTE_WIDTH-1:0] v);
      logic [BYTE_WIDTH-1:0] r;
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         r[i] = v[BYTE_WIDTH-1-i];
      end
      return r;
   endfunction

endpackage

// File: design/cce_csr.sv
// APB register file holding the CRC configuration
module cce_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cce_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [cce_pkg::CFG_WORD_WIDTH-1:0]  csr_pwdata,
   output logic [cce_pkg::CFG_WORD_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output cce_pkg::cce_cfg_type                cfg
);
   import cce_pkg::*;

   logic [CFG_WORD_WIDTH-1:0]  polynomial_ff,  polynomial_in;
   logic [CRC_WIDTH_BITS-1:0]  crc_width_ff,   crc_width_in;
   logic [CFG_WORD_WIDTH-1:0]  initial_ff,     initial_in;
   logic                       refl_in_ff,     refl_in_in;
   logic                       refl_out_ff,    refl_out_in;
   logic [CFG_WORD_WIDTH-1:0]  final_xor_ff,   final_xor_in;
   logic                       restart_ff,     restart_in;
   logic [REG_INDEX_WIDTH-1:0] index;
   logic                       wr_en;

   assign index      = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      polynomial_in = polynomial_ff;
      crc_width_in  = crc_width_ff;
      initial_in    = initial_ff;
      refl_in_in    = refl_in_ff;
      refl_out_in   = refl_out_ff;
      final_xor_in  = final_xor_ff;
      restart_in    = 1'b0;
      if (wr_en) begin
         restart_in = 1'b1;
         case (index)
            REG_POLYNOMIAL:     polynomial_in = csr_pwdata;
            REG_CRC_WIDTH:      crc_width_in  = csr_pwdata[CRC_WIDTH_BITS-1:0];
            REG_INITIAL_VALUE:  initial_in    = csr_pwdata;
            REG_REFLECT_INPUT:  refl_in_in    = csr_pwdata[0];
            REG_REFLECT_OUTPUT: refl_out_in   = csr_pwdata[0];
            REG_FINAL_XOR:      final_xor_in  = csr_pwdata;
            default:            restart_in    = 1'b0;
         endcase
      end
   end

   // restart is held through reset so the working register loads the reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         polynomial_ff <= RST_POLYNOMIAL;
         crc_width_ff  <= RST_CRC_WIDTH;
         initial_ff    <= RST_INITIAL_VALUE;
         refl_in_ff    <= RST_REFLECT_INPUT;
         refl_out_ff   <= RST_REFLECT_OUTPUT;
         final_xor_ff  <= RST_FINAL_XOR;
         restart_ff    <= 1'b1;
      end else begin
         polynomial_ff <= polynomial_in;
         crc_width_ff  <= crc_width_in;
         initial_ff    <= initial_in;
         refl_in_ff    <= refl_in_in;
         refl_out_ff   <= refl_out_in;
         final_xor_ff  <= final_xor_in;
         restart_ff    <= restart_in;
      end
   end

   always_comb begin
      case (index)
         REG_POLYNOMIAL:     csr_prdata = polynomial_ff;
         REG_CRC_WIDTH:      csr_prdata = CFG_WORD_WIDTH'(crc_width_ff);
         REG_INITIAL_VALUE:  csr_prdata = initial_ff;
         REG_REFLECT_INPUT:  csr_prdata = CFG_WORD_WIDTH'(refl_in_ff);
         REG_REFLECT_OUTPUT: csr_prdata = CFG_WORD_WIDTH'(refl_out_ff);
         REG_FINAL_XOR:      csr_prdata = final_xor_ff;
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.polynomial     = polynomial_ff;
   assign cfg.crc_width      = crc_width_ff;
   assign cfg.initial_value  = initial_ff;
   assign cfg.reflect_input  = refl_in_ff;
   assign cfg.reflect_output = refl_out_ff;
   assign cfg.final_xor      = final_xor_ff;
   assign cfg.restart        = restart_ff;

endmodule

// File: design/cce_datapath.sv
// Input register, byte-wise CRC update and result register
module cce_datapath #(
   parameter int MAX_WIDTH = cce_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cce_pkg::cce_cfg_type               cfg,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cce_pkg::BYTE_WIDTH-1:0]     req_data_byte,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cce_pkg::CRC_OUT_WIDTH-1:0]  rsp_crc_value
);
   import cce_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int IW = $clog2(MAX_WIDTH);
   localparam int XW = (MAX_WIDTH > CRC_OUT_WIDTH) ? MAX_WIDTH : CRC_OUT_WIDTH;

   logic                     s1_valid_ff, s1_valid_in;
   logic [BYTE_WIDTH-1:0]    s1_data_ff;
   logic                     s1_last_ff;
   logic [MAX_WIDTH-1:0]     crc_ff, crc_in;
   logic                     out_valid_ff, out_valid_in;
   logic [CRC_OUT_WIDTH-1:0] out_crc_ff;

   logic                     accept, advance;
   logic [WW-1:0]            eff_w;
   logic [IW-1:0]            top_idx;
   logic [MAX_WIDTH-1:0]     mask, poly_m, init_m, xor_m, b_ext, work, rev, fin;
   logic [XW-1:0]            poly_x, init_x, xor_x, fin_x;
   logic [BYTE_WIDTH-1:0]    byte_use;
   logic                     top;

   assign advance   = s1_valid_ff && (!s1_last_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (cfg.crc_width < CRC_WIDTH_BITS'(8)) begin
         eff_w = WW'(8);
      end else if (int'(cfg.crc_width) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(cfg.crc_width);
      end
      for (int i = 0; i < MAX_WIDTH; i++) begin
         mask[i] = (i < int'(eff_w));
      end
      top_idx = IW'(eff_w - WW'(1));

      poly_x = XW'(cfg.polynomial);
      init_x = XW'(cfg.initial_value);
      xor_x  = XW'(cfg.final_xor);
      poly_m = poly_x[MAX_WIDTH-1:0] & mask;
      init_m = init_x[MAX_WIDTH-1:0] & mask;
      xor_m  = xor_x[MAX_WIDTH-1:0] & mask;

      byte_use = cfg.reflect_input ? rev8(s1_data_ff) : s1_data_ff;
      b_ext    = MAX_WIDTH'(byte_use) << (eff_w - WW'(8));

      work = (crc_ff & mask) ^ b_ext;
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         top  = work[top_idx];
         work = (work << 1) & mask;
         if (top) begin
            work = work ^ poly_m;
         end
      end

      for (int i = 0; i < MAX_WIDTH; i++) begin
         if (i < int'(eff_w)) begin
            rev[i] = work[IW'(int'(eff_w) - 1 - i)];
         end else begin
            rev[i] = 1'b0;
         end
      end
      fin   = ((cfg.reflect_output ? rev : work) ^ xor_m) & mask;
      fin_x = XW'(fin);
   end

   always_comb begin
      if (cfg.restart) begin
         crc_in = init_m;
      end else if (advance) begin
         crc_in = s1_last_ff ? init_m : work;
      end else begin
         crc_in = crc_ff;
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (advance && s1_last_ff) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      if (accept) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last;
      end
      if (advance && s1_last_ff) begin
         out_crc_ff <= fin_x[CRC_OUT_WIDTH-1:0];
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_crc_value = out_crc_ff;

endmodule

// File: design/configurable_crc_engine.sv
// Top level of the configurable byte-wise CRC engine
// Path: a byte marked last passes the input register and then the result register.
// Throughput: one byte per cycle while the result side is free; the input register
// feeds a single pass of eight shift-XOR steps into the working and result registers.
// Reset: synchronous, active high; loads the default CRC-32 settings and the
// working register takes the initial value in the first cycle after reset.
module configurable_crc_engine #(
   parameter int MAX_WIDTH = cce_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cce_pkg::BYTE_WIDTH-1:0]      req_data_byte,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cce_pkg::CRC_OUT_WIDTH-1:0]   rsp_crc_value,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cce_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [cce_pkg::CFG_WORD_WIDTH-1:0]  csr_pwdata,
   output logic [cce_pkg::CFG_WORD_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import cce_pkg::*;

   cce_cfg_type cfg;

   cce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cce_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_crc_value (rsp_crc_value)
   );

endmodule

// File: design/cce_checker.sv
// Port-level checks for the CRC engine and their bind to the top level
`include "configurable_crc_engine_defines.svh"

module cce_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [cce_pkg::CRC_OUT_WIDTH-1:0]   rsp_crc_value,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [cce_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input logic [cce_pkg::CFG_WORD_WIDTH-1:0]  csr_pwdata,
   input logic [cce_pkg::CFG_WORD_WIDTH-1:0]  csr_prdata,
   input logic                                csr_pready
);
   import cce_pkg::*;

   logic poly_addr;
   logic poly_write;
   logic poly_rd;
   logic rsp_held;
   assign poly_addr  = (csr_paddr[CSR_ADDR_WIDTH-1:2] == REG_POLYNOMIAL);
   assign poly_write = csr_psel && csr_penable && csr_pwrite && csr_pready && poly_addr;
   assign poly_rd    = !csr_pwrite && poly_addr;
   assign rsp_held   = rsp_valid && rsp_stall;

   // a stalled result transfer holds
   `CCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_crc_value))

   // input never stalls while the result side is free
   `CCE_ASSERT_NOW(a_no_stall_when_drained, clock, reset, !rsp_stall, !req_stall)

   // input never stalls with no result waiting
   `CCE_ASSERT_NOW(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)

   // polynomial read straight after a write returns the written value
   `CCE_ASSERT_NOW(a_poly_readback, clock, reset, $past(poly_write) && poly_rd,
                   csr_prdata == $past(csr_pwdata))

endmodule

bind configurable_crc_engine cce_checker u_cce_checker (.*);

// File: tb/sv/configurable_crc_engine_test.sv
// Self-checking testbench for the configurable CRC engine: byte stream in, CRC per message out
`timescale 1ns / 100ps

module configurable_crc_engine_test;
   import cce_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 200;
   localparam int DRAIN_WAIT  = 8;

   // indexes past the register list, writes there must change nothing
   localparam logic [REG_INDEX_WIDTH-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_UNMAPPED_HI = 3'd7;

   typedef enum int {
      SET_CRC32,
      SET_CCITT,
      SET_CRC8,
      SET_RANDOM,
      SET_EXTREME,
      SET_ODD_WIDTH
   } setting_kind_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  last;
   } msg_byte_type;

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [BYTE_WIDTH-1:0]     req_data_byte  = '0;
   logic                      req_last       = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic [CRC_OUT_WIDTH-1:0]  rsp_crc_value;
   logic                      csr_psel       = 1'b0;
   logic                      csr_penable    = 1'b0;
   logic                      csr_pwrite     = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr      = '0;
   logic [CFG_WORD_WIDTH-1:0] csr_pwdata     = '0;
   logic [CFG_WORD_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   configurable_crc_engine uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_crc_value (rsp_crc_value),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #5 clock = ~clock;

   // predictor copy of the settings and the running CRC
   logic [CFG_WORD_WIDTH-1:0] cfg_poly   = RST_POLYNOMIAL;
   logic [CRC_WIDTH_BITS-1:0] cfg_width  = RST_CRC_WIDTH;
   logic [CFG_WORD_WIDTH-1:0] cfg_init   = RST_INITIAL_VALUE;
   logic                      cfg_refin  = RST_REFLECT_INPUT;
   logic                      cfg_refout = RST_REFLECT_OUTPUT;
   logic [CFG_WORD_WIDTH-1:0] cfg_xorout = RST_FINAL_XOR;
   logic [CRC_OUT_WIDTH-1:0]  crc_acc    = RST_INITIAL_VALUE;

   msg_byte_type             byte_queue[$];
   logic [CRC_OUT_WIDTH-1:0] crc_expected[$];

   int          mismatch_count = 0;
   int          cycle_count    = 0;
   logic        req_fire       = 1'b0;
   bit          send_idle_mode = 1'b0;
   bit          recv_idle_mode = 1'b0;
   int unsigned send_gap_left  = 0;
   int unsigned stall_left     = 0;
   int unsigned hold_left      = 0;
   int unsigned hold_req_count = 0;
   int unsigned hold_seen      = 0;

   function automatic int unsigned active_width();
      if (cfg_width < 8) return 8;
      if (cfg_width > MAX_WIDTH_DEFAULT) return MAX_WIDTH_DEFAULT;
      return cfg_width;
   endfunction

   function automatic logic [31:0] width_mask(input int unsigned w);
      logic [63:0] m;
      m = (64'd1 << w) - 64'd1;
      return m[31:0];
   endfunction

   function automatic logic [31:0] mirror_bits(input logic [31:0] v, input int unsigned n);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < n; i++) r[n-1-i] = v[i];
      return r;
   endfunction

   function automatic void crc_predict(input logic [BYTE_WIDTH-1:0] data_byte, input logic last);
      int unsigned w;
      logic [31:0] mask;
      logic [31:0] poly;
      logic [31:0] r;
      logic [7:0]  b;
      logic        top;
      w    = active_width();
      mask = width_mask(w);
      poly = cfg_poly & mask;
      r    = crc_acc & mask;
      b    = cfg_refin ? rev8(data_byte) : data_byte;
      r    = r ^ ({24'd0, b} << (w - 8));
      for (int i = 0; i < 8; i++) begin
         top = r[w-1];
         r   = (r << 1) & mask;
         if (top) r = r ^ poly;
      end
      crc_acc = r;
      if (last) begin
         if (cfg_refout) r = mirror_bits(r, w);
         crc_expected.push_back((r ^ cfg_xorout) & mask);
         crc_acc = cfg_init & mask;
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // driver: a stalled transfer keeps its payload
   always @(negedge clock) begin
      msg_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         req_valid <= 1'b1;
      end else if (send_gap_left > 0) begin
         req_valid <= 1'b0;
         send_gap_left--;
      end else if (byte_queue.size() > 0) begin
         nxt = byte_queue.pop_front();
         req_data_byte <= nxt.data_byte;
         req_last      <= nxt.last;
         req_valid     <= 1'b1;
         send_gap_left = send_idle_mode ? pick_gap() : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver back-pressure, with a long hold on request
   always @(negedge clock) begin
      int unsigned run;
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_req_count != hold_seen) begin
         hold_seen = hold_req_count;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (recv_idle_mode && $urandom_range(2) == 0) begin
         run = pick_gap();
         rsp_stall <= (run != 0);
         stall_left = (run > 0) ? run - 1 : 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor and predictor, sampled at the rising edge
   always @(posedge clock) begin
      logic [CRC_OUT_WIDTH-1:0] want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         req_fire <= !reset && req_valid && !req_stall;
         if (!reset) begin
            if (rsp_valid && !rsp_stall) begin
               if (crc_expected.size() == 0) begin
                  $error("crc_value: no transfer expected, actual %h", rsp_crc_value);
                  mismatch_count++;
               end else begin
                  want = crc_expected.pop_front();
                  if (rsp_crc_value !== want) begin
                     $error("crc_value: expected %h, actual %h", want, rsp_crc_value);
                     mismatch_count++;
                  end
               end
            end
            if (req_valid && !req_stall) crc_predict(req_data_byte, req_last);
         end
      end
   end

   task automatic push_byte(input logic [7:0] data_byte, input logic last);
      msg_byte_type item;
      item.data_byte = data_byte;
      item.last      = last;
      byte_queue.push_back(item);
   endtask

   task automatic push_message(input int unsigned len, input bit terminate);
      for (int i = 0; i < len; i++)
         push_byte(8'($urandom_range(255)), terminate && (i == len - 1));
   endtask

   task automatic wait_drained();
      @(posedge clock);
      #1;
      while (byte_queue.size() != 0 || req_valid || crc_expected.size() != 0) begin
         @(posedge clock);
         #1;
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic cfg_write(input logic [REG_INDEX_WIDTH-1:0] index, input logic [31:0] value);
      bit known;
      known = 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_POLYNOMIAL:     cfg_poly   = value;
         REG_CRC_WIDTH:      cfg_width  = value[CRC_WIDTH_BITS-1:0];
         REG_INITIAL_VALUE:  cfg_init   = value;
         REG_REFLECT_INPUT:  cfg_refin  = value[0];
         REG_REFLECT_OUTPUT: cfg_refout = value[0];
         REG_FINAL_XOR:      cfg_xorout = value;
         default:            known      = 1'b0;
      endcase
      if (known) crc_acc = cfg_init & width_mask(active_width());
   endtask

   task automatic cfg_write_all(input logic [31:0] poly, input logic [31:0] width,
                                input logic [31:0] init, input logic [31:0] refin,
                                input logic [31:0] refout, input logic [31:0] xorout);
      cfg_write(REG_POLYNOMIAL, poly);
      cfg_write(REG_CRC_WIDTH, width);
      cfg_write(REG_INITIAL_VALUE, init);
      cfg_write(REG_REFLECT_INPUT, refin);
      cfg_write(REG_REFLECT_OUTPUT, refout);
      cfg_write(REG_FINAL_XOR, xorout);
   endtask

   task automatic apply_setting(input setting_kind_type kind);
      case (kind)
         SET_CRC32:
            cfg_write_all(32'h04C1_1DB7, 32, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFF);
         SET_CCITT:
            cfg_write_all(32'h0000_1021, 16, 32'h0000_FFFF, 0, 0, 32'h0);
         SET_CRC8:
            cfg_write_all(32'h0000_0007, 8, 32'h0, 0, 0, 32'h0);
         SET_RANDOM:
            cfg_write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         SET_EXTREME:
            cfg_write_all(32'hFFFF_FFFF, $urandom_range(1) ? 8 : 32, 32'h0,
                          $urandom_range(1), $urandom_range(1), 32'hFFFF_FFFF);
         default:
            cfg_write_all($urandom, $urandom_range(1) ? $urandom_range(7) : $urandom_range(63, 33),
                          $urandom, $urandom_range(1), $urandom_range(1), $urandom);
      endcase
   endtask

   initial begin
      int unsigned total;
      int unsigned len;
      int unsigned r;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (4) @(negedge clock);

      // reset settings: check string, all-zero and all-one bytes
      for (int i = 0; i < 9; i++) push_byte(8'h31 + 8'(i), i == 8);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      wait_drained();

      // writes past the register list leave the message running
      push_byte(8'hA5, 1'b0);
      wait_drained();
      cfg_write(REG_UNMAPPED_LO, $urandom);
      cfg_write(REG_UNMAPPED_HI, $urandom);
      push_byte(8'h3C, 1'b1);
      wait_drained();

      // a real write mid-message restarts it
      push_byte(8'h11, 1'b0);
      wait_drained();
      cfg_write(REG_REFLECT_INPUT, 32'hFFFF_FFFE);
      push_byte(8'h22, 1'b1);
      wait_drained();

      // width below range, then above range
      cfg_write(REG_CRC_WIDTH, 32'h0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h00, 1'b1);
      wait_drained();
      cfg_write(REG_CRC_WIDTH, 32'hFFFF_FFFF);
      push_byte(8'h80, 1'b1);
      push_byte(8'h01, 1'b1);
      wait_drained();

      cfg_write_all(32'hFF, 8, 32'h0, 0, 0, 32'h0);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h5A, 1'b0);
      push_byte(8'hC3, 1'b1);
      wait_drained();

      for (int phase = 0; phase < 11; phase++) begin
         apply_setting(setting_kind_type'(phase % 6));
         if (phase == 3) begin
            // receiver holds off while single-byte messages keep coming
            send_idle_mode = 1'b0;
            recv_idle_mode = 1'b0;
            hold_req_count++;
            for (int i = 0; i < 60; i++) push_byte(8'($urandom_range(255)), 1'b1);
            wait_drained();
         end
         send_idle_mode = (phase % 4) != 1;
         recv_idle_mode = (phase % 4) != 2;
         total = 0;
         while (total < 75) begin
            r = $urandom_range(99);
            if (r < 70) len = $urandom_range(8, 1);
            else if (r < 95) len = $urandom_range(40, 9);
            else len = $urandom_range(120, 41);
            push_message(len, $urandom_range(19) != 0);
            total += len;
         end
         if ($urandom_range(2) == 0) push_message($urandom_range(6, 1), 1'b0);
         wait_drained();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (crc_expected.size() != 0) begin
         $error("crc_value: %0d transfers never arrived", crc_expected.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
